// ===== hdl/dlp_pkg.sv =====
// Shared constants and types for the DAG longest-path engine.
`default_nettype none
package dlp_pkg;
  localparam int unsigned MaxNodes    = 128;
  localparam int unsigned NodeBits    = $clog2(MaxNodes);
  localparam int unsigned CountBits   = NodeBits + 1;
  localparam int unsigned MaxEdges    = 8192;
  localparam int unsigned EdgeBits    = $clog2(MaxEdges) + 1;
  localparam int unsigned LenBits     = 16;
  localparam int unsigned CostBits    = 24;
  localparam int unsigned CfgBits     = 8;
  localparam int unsigned PairDepth   = MaxNodes * MaxNodes;
  localparam int unsigned PairBits    = 2 * NodeBits;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_CYCLE = 2'd1,
    STATUS_BAD   = 2'd2
  } status_e;

  typedef struct packed {
    logic [EdgeBits-1:0] mult;
    logic [LenBits-1:0]  len;
  } pair_t;
endpackage
`default_nettype wire

// ===== hdl/dlp_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module dlp_ram #(
  parameter int unsigned Width    = 8,
  parameter int unsigned Depth    = 16,
  parameter int unsigned AddrBits = $clog2(Depth)
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/dag_longest_path_topo.sv =====
// Top level of the DAG longest-path engine: edge loading, Kahn walk and result.
// Edges load one per cycle while in_stall_o is low; after the last edge the solve
// scans for ready nodes, processes the edge row of each popped node, then takes the maximum.
// One graph at a time; a clearing pass over the n*n pairs (n = node count) follows every
// result and sets the pair, degree and finish memories back, input stalled meanwhile.
// Reset: asynchronous, active low; a clearing pass over the whole pair memory follows it.
`default_nettype none
module dag_longest_path_topo
  import dlp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgBits-1:0]   cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 edge_valid_i,
  input  wire logic [NodeBits-1:0]  edge_source_i,
  input  wire logic [NodeBits-1:0]  edge_target_i,
  input  wire logic [LenBits-1:0]   edge_length_i,
  input  wire logic                 last_edge_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                status_o,
  output logic [CostBits-1:0]       longest_time_o
);
  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_FLUSH    = 13'b0000000000010,
    ST_SCAN_RD  = 13'b0000000000100,
    ST_SCAN_CHK = 13'b0000000001000,
    ST_POP_RD   = 13'b0000000010000,
    ST_POP_CUR  = 13'b0000000100000,
    ST_POP_FIN  = 13'b0000001000000,
    ST_EDGE_RD  = 13'b0000010000000,
    ST_EDGE_UPD = 13'b0000100000000,
    ST_MAX_RD   = 13'b0001000000000,
    ST_MAX_UPD  = 13'b0010000000000,
    ST_DONE     = 13'b0100000000000,
    ST_CLEAR    = 13'b1000000000000
  } state_e;

  state_e               state_q, state_d;
  logic [CfgBits-1:0]   ncfg_q;
  logic [CountBits-1:0] n_eff;
  logic [CountBits-1:0] idx_q, idx_d, depth_q, depth_d, done_q, done_d;
  logic [CountBits-1:0] row_q, row_d, col_q, col_d, clr_n_q, clr_n_d;
  logic [NodeBits-1:0]  cur_q, cur_d;
  logic [CostBits-1:0]  fcur_q, fcur_d, best_q, best_d;
  logic [1:0]           res_q, res_d;
  logic                 bad_q, bad_d;
  logic [EdgeBits-1:0]  ecnt_q, ecnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_status_q;
  logic [CostBits-1:0]  out_time_q;

  logic                 s1_store_q, hit_pair_q, hit_deg_q;
  logic [NodeBits-1:0]  s1_src_q, s1_tgt_q;
  logic [LenBits-1:0]   s1_len_q;
  logic [EdgeBits-1:0]  fwd_mult_q, fwd_deg_q, mult_new, deg_new;

  logic                 in_acc, bad_in, store_in;

  logic                 pair_we, deg_we, fin_we, stk_we;
  logic [PairBits-1:0]  pair_waddr, pair_raddr;
  pair_t                pair_wdata, pair_rd;
  logic [NodeBits-1:0]  deg_waddr, deg_raddr, fin_waddr, fin_raddr, stk_waddr, stk_raddr;
  logic [EdgeBits-1:0]  deg_wdata, deg_rd;
  logic [CostBits-1:0]  fin_wdata, fin_rd;
  logic [NodeBits-1:0]  stk_wdata, stk_rd;
  logic [CountBits-1:0] depth_m1;
  logic [CostBits:0]    sum;
  logic [CostBits-1:0]  cand;

  assign cfg_ready_o = 1'b1;
  assign n_eff = (ncfg_q == '0) ? CountBits'(1) :
                 (ncfg_q > CfgBits'(MaxNodes)) ? CountBits'(MaxNodes) : CountBits'(ncfg_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign bad_in     = edge_valid_i && ((CountBits'(edge_source_i) >= n_eff) ||
                                       (CountBits'(edge_target_i) >= n_eff));
  assign store_in   = edge_valid_i && !bad_in && (ecnt_q < EdgeBits'(MaxEdges));

  assign mult_new = (hit_pair_q ? fwd_mult_q : pair_rd.mult) + EdgeBits'(1);
  assign deg_new  = (hit_deg_q ? fwd_deg_q : deg_rd) + EdgeBits'(1);

  assign depth_m1 = depth_q - CountBits'(1);
  assign sum  = {1'b0, fcur_q} + (CostBits+1)'(pair_rd.len);
  assign cand = sum[CostBits] ? {CostBits{1'b1}} : sum[CostBits-1:0];

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign longest_time_o = out_time_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    depth_d     = depth_q;
    done_d      = done_q;
    row_d       = row_q;
    col_d       = col_q;
    clr_n_d     = clr_n_q;
    cur_d       = cur_q;
    fcur_d      = fcur_q;
    best_d      = best_q;
    res_d       = res_q;
    bad_d       = bad_q;
    ecnt_d      = ecnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    pair_we     = 1'b0;
    pair_waddr  = {s1_src_q, s1_tgt_q};
    pair_wdata  = '{mult: mult_new, len: s1_len_q};
    pair_raddr  = {edge_source_i, edge_target_i};
    deg_we      = 1'b0;
    deg_waddr   = s1_tgt_q;
    deg_wdata   = deg_new;
    deg_raddr   = edge_target_i;
    fin_we      = 1'b0;
    fin_waddr   = idx_q[NodeBits-1:0];
    fin_wdata   = cand;
    fin_raddr   = idx_q[NodeBits-1:0];
    stk_we      = 1'b0;
    stk_waddr   = depth_q[NodeBits-1:0];
    stk_wdata   = idx_q[NodeBits-1:0];
    stk_raddr   = depth_m1[NodeBits-1:0];

    if (s1_store_q) begin
      pair_we = 1'b1;
      deg_we  = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (bad_in) begin
            bad_d = 1'b1;
          end
          if (store_in) begin
            ecnt_d = ecnt_q + EdgeBits'(1);
          end
          if (last_edge_i) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        idx_d = '0;
        if (bad_q) begin
          res_d   = STATUS_BAD;
          best_d  = '0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        deg_raddr = idx_q[NodeBits-1:0];
        state_d   = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (deg_rd == '0 && depth_q < CountBits'(MaxNodes)) begin
          stk_we  = 1'b1;
          depth_d = depth_q + CountBits'(1);
        end
        idx_d   = idx_q + CountBits'(1);
        state_d = (idx_d == n_eff) ? ST_POP_RD : ST_SCAN_RD;
      end
      ST_POP_RD: begin
        if (depth_q == '0) begin
          idx_d  = '0;
          best_d = '0;
          if (done_q < n_eff) begin
            res_d   = STATUS_CYCLE;
            state_d = ST_DONE;
          end else begin
            res_d   = STATUS_OK;
            state_d = ST_MAX_RD;
          end
        end else begin
          depth_d = depth_m1;
          state_d = ST_POP_CUR;
        end
      end
      ST_POP_CUR: begin
        cur_d     = stk_rd;
        fin_raddr = stk_rd;
        if (CountBits'(stk_rd) >= n_eff) begin
          state_d = ST_POP_RD;
        end else begin
          done_d  = done_q + CountBits'(1);
          state_d = ST_POP_FIN;
        end
      end
      ST_POP_FIN: begin
        fcur_d  = fin_rd;
        idx_d   = '0;
        state_d = ST_EDGE_RD;
      end
      ST_EDGE_RD: begin
        pair_raddr = {cur_q, idx_q[NodeBits-1:0]};
        deg_raddr  = idx_q[NodeBits-1:0];
        fin_raddr  = idx_q[NodeBits-1:0];
        state_d    = ST_EDGE_UPD;
      end
      ST_EDGE_UPD: begin
        deg_waddr = idx_q[NodeBits-1:0];
        if (pair_rd.mult != '0) begin
          if (cand > fin_rd) begin
            fin_we = 1'b1;
            if (idx_q[NodeBits-1:0] == cur_q) begin
              fcur_d = cand;
            end
          end
          if (deg_rd > pair_rd.mult) begin
            deg_we    = 1'b1;
            deg_wdata = deg_rd - pair_rd.mult;
          end else if (deg_rd != '0) begin
            deg_we    = 1'b1;
            deg_wdata = '0;
            if (depth_q < CountBits'(MaxNodes)) begin
              stk_we  = 1'b1;
              depth_d = depth_q + CountBits'(1);
            end
          end
        end
        idx_d   = idx_q + CountBits'(1);
        state_d = (idx_d == n_eff) ? ST_POP_RD : ST_EDGE_RD;
      end
      ST_MAX_RD: begin
        state_d = ST_MAX_UPD;
      end
      ST_MAX_UPD: begin
        if (fin_rd > best_q) begin
          best_d = fin_rd;
        end
        idx_d   = idx_q + CountBits'(1);
        state_d = (idx_d == n_eff) ? ST_DONE : ST_MAX_RD;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          clr_n_d     = n_eff;
          row_d       = '0;
          col_d       = '0;
          depth_d     = '0;
          done_d      = '0;
          bad_d       = 1'b0;
          ecnt_d      = '0;
          state_d     = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        pair_we    = 1'b1;
        pair_waddr = {row_q[NodeBits-1:0], col_q[NodeBits-1:0]};
        pair_wdata = '0;
        if (col_q == '0) begin
          deg_we    = 1'b1;
          deg_waddr = row_q[NodeBits-1:0];
          deg_wdata = '0;
          fin_we    = 1'b1;
          fin_waddr = row_q[NodeBits-1:0];
          fin_wdata = '0;
        end
        col_d = col_q + CountBits'(1);
        if (col_d == clr_n_q) begin
          col_d = '0;
          row_d = row_q + CountBits'(1);
          if (row_d == clr_n_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ncfg_q      <= CfgBits'(1);
      idx_q       <= '0;
      depth_q     <= '0;
      done_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      clr_n_q     <= CountBits'(MaxNodes);
      bad_q       <= 1'b0;
      ecnt_q      <= '0;
      out_valid_q <= 1'b0;
      s1_store_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      depth_q     <= depth_d;
      done_q      <= done_d;
      row_q       <= row_d;
      col_q       <= col_d;
      clr_n_q     <= clr_n_d;
      bad_q       <= bad_d;
      ecnt_q      <= ecnt_d;
      out_valid_q <= out_valid_d;
      s1_store_q  <= in_acc && store_in;
      if (cfg_valid_i && cfg_ready_o) begin
        ncfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    fcur_q <= fcur_d;
    best_q <= best_d;
    res_q  <= res_d;
    if (in_acc) begin
      s1_src_q   <= edge_source_i;
      s1_tgt_q   <= edge_target_i;
      s1_len_q   <= edge_length_i;
      hit_pair_q <= s1_store_q && (s1_src_q == edge_source_i) &&
                    (s1_tgt_q == edge_target_i);
      hit_deg_q  <= s1_store_q && (s1_tgt_q == edge_target_i);
      fwd_mult_q <= mult_new;
      fwd_deg_q  <= deg_new;
    end
    if (state_q == ST_DONE && out_valid_d && !(out_valid_q && out_stall_i)) begin
      out_status_q <= res_q;
      out_time_q   <= best_q;
    end
  end

  dlp_ram #(.Width($bits(pair_t)), .Depth(PairDepth)) u_pair_ram (
    .clk_i  (clk_i),
    .we_i   (pair_we),
    .waddr_i(pair_waddr),
    .wdata_i(pair_wdata),
    .raddr_i(pair_raddr),
    .rdata_o(pair_rd)
  );

  dlp_ram #(.Width(EdgeBits), .Depth(MaxNodes)) u_deg_ram (
    .clk_i  (clk_i),
    .we_i   (deg_we),
    .waddr_i(deg_waddr),
    .wdata_i(deg_wdata),
    .raddr_i(deg_raddr),
    .rdata_o(deg_rd)
  );

  dlp_ram #(.Width(CostBits), .Depth(MaxNodes)) u_fin_ram (
    .clk_i  (clk_i),
    .we_i   (fin_we),
    .waddr_i(fin_waddr),
    .wdata_i(fin_wdata),
    .raddr_i(fin_raddr),
    .rdata_o(fin_rd)
  );

  dlp_ram #(.Width(NodeBits), .Depth(MaxNodes)) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rd)
  );

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_edge_i |=> in_stall_o)
    else $error("Input accepted right after the last edge of a graph.");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("Result raised outside the done state.");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CountBits'(MaxNodes))
    else $error("Ready stack overflow.");

  a_store_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_store_q |-> $past(state_q == ST_IDLE))
    else $error("Edge write-back without an accepted edge.");
endmodule
`default_nettype wire
